@@ hdl/b2da_pkg.sv @@
// b2da_pkg: shared constants, microcode word layout and program ROM for the
// binary-to-decimal ASCII converter. No dependencies.
`default_nettype none

package b2da_pkg;

  localparam int MAX_DIGITS = 10;
  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 4;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int PC_W       = 3;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'd32;

  // floor(x / 10) == (x * 0xCCCCCCCD) >> 35 for every 32-bit x
  localparam logic [VALUE_W-1:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int                 RECIP_SHIFT = 35;

  // program addresses
  localparam logic [PC_W-1:0] PC_IDLE  = 3'd0;
  localparam logic [PC_W-1:0] PC_TEST  = 3'd1;
  localparam logic [PC_W-1:0] PC_MUL   = 3'd2;
  localparam logic [PC_W-1:0] PC_SPLIT = 3'd3;
  localparam logic [PC_W-1:0] PC_DIGIT = 3'd4;
  localparam logic [PC_W-1:0] PC_SPACE = 3'd5;
  localparam logic [PC_W-1:0] PC_ZERO  = 3'd6;

  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_ZERO,   // remaining value is zero
    CND_MORE,   // quotient nonzero and buffer not full
    CND_DIGS    // more than one digit still to send
  } cond_t;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_DIGIT,
    OUT_SPACE,
    OUT_ZERO
  } out_sel_t;

  typedef struct packed {
    logic            ld_in;   // wait for and take an input transaction
    logic            mul;     // start divide-by-ten multiply
    logic            split;   // store remainder, keep quotient
    out_sel_t        out_sel; // load output register (waits for free slot)
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{ld_in: 1'b0, mul: 1'b0, split: 1'b0, out_sel: OUT_NONE,
          cond: CND_ALWAYS, target: PC_IDLE};
    case (pc)
      PC_IDLE: begin
        w.ld_in = 1'b1;
        w.cond  = CND_NEVER;
      end
      PC_TEST: begin
        w.cond   = CND_ZERO;
        w.target = PC_ZERO;
      end
      PC_MUL: begin
        w.mul  = 1'b1;
        w.cond = CND_NEVER;
      end
      PC_SPLIT: begin
        w.split  = 1'b1;
        w.cond   = CND_MORE;
        w.target = PC_MUL;
      end
      PC_DIGIT: begin
        w.out_sel = OUT_DIGIT;
        w.cond    = CND_DIGS;
        w.target  = PC_DIGIT;
      end
      PC_SPACE: begin
        w.out_sel = OUT_SPACE;
      end
      PC_ZERO: begin
        w.out_sel = OUT_ZERO;
      end
      default: begin
        w.cond   = CND_ALWAYS;
        w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ hdl/b2da_div10.sv @@
// b2da_div10: divide by ten via a registered reciprocal multiply.
// Depends on b2da_pkg.
`default_nettype none

module b2da_div10 (
  input  wire                            clk,
  input  wire                            start,
  input  wire  [b2da_pkg::VALUE_W-1:0]   dividend,
  output logic [b2da_pkg::VALUE_W-1:0]   quotient,
  output logic [b2da_pkg::DIGIT_W-1:0]   remainder
);
  import b2da_pkg::*;

  logic [2*VALUE_W-1:0] prod_r;
  logic [VALUE_W-1:0]   dvd_r;
  logic [VALUE_W-1:0]   q10;
  logic [VALUE_W-1:0]   rem_full;

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= dividend * RECIP10;
      dvd_r  <= dividend;
    end
  end

  assign quotient  = VALUE_W'(prod_r >> RECIP_SHIFT);
  assign q10       = (quotient << 3) + (quotient << 1);
  assign rem_full  = dvd_r - q10;
  assign remainder = rem_full[DIGIT_W-1:0];

endmodule

`default_nettype wire

@@ hdl/binary_to_decimal_ascii.sv @@
// binary_to_decimal_ascii: top level, microcoded converter from a 32-bit
// unsigned value to decimal ASCII characters. Uses b2da_pkg, b2da_div10.
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  input   | in_valid, in_ready, in_value[31:0]     | in
//  result  | out_valid, out_ready, out_ascii_char,  | out
//          | out_last_char                          |
//
// A value occupies the sequencer from the cycle it is accepted in through a
// test for zero, a multiply and a split step per digit in the shared
// divide-by-ten multiplier, and one load per character (the digits and the
// space). Zero is tested and then loads a lone '0'. Output back-pressure
// stalls the character loads. The next value is taken while the final
// character still sits in the output register.
// Reset (rst_n, synchronous) clears the program counter, working value, digit
// count and output valid, and holds in_ready low; the digit buffer is not
// cleared.
`default_nettype none

module binary_to_decimal_ascii (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  [b2da_pkg::VALUE_W-1:0]   in_value,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [b2da_pkg::CHAR_W-1:0]    out_ascii_char,
  output logic                           out_last_char
);
  import b2da_pkg::*;

  // sequencer
  logic [PC_W-1:0]    pc_r, pc_nxt;
  ucode_t             uw;
  logic               go;
  logic               cond_hit;
  logic               slot_free;

  // datapath
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DIGIT_W-1:0] digit_buf [MAX_DIGITS];
  logic [VALUE_W-1:0] quot;
  logic [DIGIT_W-1:0] rem;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r;
  logic               out_last_r;
  logic               out_load;

  assign uw        = ucode_rom(pc_r);
  assign slot_free = !out_valid_r || out_ready;

  // a step stalls while it waits for input or for a free output slot
  assign go = !(uw.ld_in && !in_valid) && !((uw.out_sel != OUT_NONE) && !slot_free);

  assign in_ready = uw.ld_in && rst_n;
  assign out_load = go && (uw.out_sel != OUT_NONE);

  b2da_div10 u_div10 (
    .clk       (clk),
    .start     (go && uw.mul),
    .dividend  (val_r),
    .quotient  (quot),
    .remainder (rem)
  );

  always_comb begin
    case (uw.cond)
      CND_NEVER:  cond_hit = 1'b0;
      CND_ALWAYS: cond_hit = 1'b1;
      CND_ZERO:   cond_hit = (val_r == '0);
      CND_MORE:   cond_hit = (quot != '0) && (cnt_r != CNT_W'(MAX_DIGITS - 1));
      CND_DIGS:   cond_hit = (cnt_r != CNT_W'(1));
      default:    cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt  = pc_r;
    val_nxt = val_r;
    cnt_nxt = cnt_r;
    if (go) begin
      pc_nxt = cond_hit ? uw.target : pc_r + 1'b1;
      if (uw.ld_in) begin
        val_nxt = in_value;
        cnt_nxt = '0;
      end
      if (uw.split) begin
        val_nxt = quot;
        cnt_nxt = cnt_r + 1'b1;
      end
      if (uw.out_sel == OUT_DIGIT) begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= PC_IDLE;
      val_r <= '0;
      cnt_r <= '0;
    end else begin
      pc_r  <= pc_nxt;
      val_r <= val_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // digit buffer, least significant digit at index 0
  always_ff @(posedge clk) begin
    if (go && uw.split) begin
      digit_buf[IDX_W'(cnt_r)] <= rem;
    end
  end

  // output register decouples the sequencer from the consumer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // digits go out most significant first: top of the buffer down to index 0
  always_ff @(posedge clk) begin
    if (out_load) begin
      case (uw.out_sel)
        OUT_DIGIT: begin
          out_char_r <= ASCII_ZERO + CHAR_W'(digit_buf[IDX_W'(cnt_r - 1'b1)]);
          out_last_r <= 1'b0;
        end
        OUT_SPACE: begin
          out_char_r <= ASCII_SPACE;
          out_last_r <= 1'b1;
        end
        OUT_ZERO: begin
          out_char_r <= ASCII_ZERO;
          out_last_r <= 1'b1;
        end
        default: begin
          out_char_r <= out_char_r;
          out_last_r <= out_last_r;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ascii_char = out_char_r;
  assign out_last_char  = out_last_r;

  // digit count never exceeds the buffer size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_DIGITS))
    else $error("digit count beyond buffer size");

  // a new input transaction restarts the digit count
  a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (cnt_r == '0))
    else $error("digit count not cleared after input transaction");

  // a digit is only sent while the buffer holds one
  a_digit_avail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (uw.out_sel == OUT_DIGIT)) |-> (cnt_r != '0))
    else $error("digit sent from empty buffer");

  // the sequencer never loads the output register over an untaken transaction
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

endmodule

`default_nettype wire

@@ test/binary_to_decimal_ascii_tb.sv @@
// binary_to_decimal_ascii_tb: self-checking testbench for the 32-bit binary to
// decimal ASCII converter. Depends on b2da_pkg and binary_to_decimal_ascii.
`default_nettype none

module binary_to_decimal_ascii_tb;

  import b2da_pkg::*;

  // one expected character transaction on the result channel
  typedef struct packed {
    logic [CHAR_W-1:0] ascii;
    logic              last;
  } char_rec_t;

  localparam int N_DIR  = 20;   // directed rows
  localparam int N_RAND = 190;  // random values after the directed part

  logic               clk      = 1'b0;
  logic               rst_n    = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [VALUE_W-1:0] in_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CHAR_W-1:0]  out_ascii_char;
  logic               out_last_char;

  char_rec_t   expected_chars[$];   // characters still owed by the block, oldest first
  char_rec_t   got_char;
  int unsigned err_count   = 0;
  int unsigned burst_left  = 0;     // values left in the sender's current burst
  bit          holdoff_req  = 1'b0; // asks the receiver for one long stall
  bit          holdoff_done = 1'b0;

  // directed stimulus: text is typed in only where it is obvious, else ""
  logic [VALUE_W-1:0] dir_value[N_DIR];
  string              dir_text[N_DIR];

  binary_to_decimal_ascii DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_ascii_char(out_ascii_char),
    .out_last_char (out_last_char)
  );

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  // Hard stop; far beyond the slowest legal run (every value at ten digits
  // and the receiver at its worst stall pattern).
  initial begin : watchdog
    #5_000_000;
    $display("FAIL binary_to_decimal_ascii");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: split the value into decimal digits by repeated division,
  // then queue them most significant first. Zero gives a lone '0'; anything
  // else ends with a space, and only the final character carries last.
  // ---------------------------------------------------------------------------
  task automatic predict_chars(input logic [VALUE_W-1:0] value);
    logic [DIGIT_W-1:0] digits[MAX_DIGITS];
    logic [VALUE_W-1:0] rest;
    int                 n_dig;
    int                 k;
    rest  = value;
    n_dig = 0;
    if (rest == '0) begin
      expected_chars.push_back('{ascii: ASCII_ZERO, last: 1'b1});
    end else begin
      while (rest != '0 && n_dig < MAX_DIGITS) begin
        digits[n_dig] = DIGIT_W'(rest % 10);
        rest          = rest / 10;
        n_dig++;
      end
      for (k = n_dig - 1; k >= 0; k--)
        expected_chars.push_back('{ascii: ASCII_ZERO + CHAR_W'(digits[k]), last: 1'b0});
      expected_chars.push_back('{ascii: ASCII_SPACE, last: 1'b1});
    end
  endtask

  // hand-written expectation: one transaction per character, last on the final one
  task automatic queue_text(input string text);
    int k;
    for (k = 0; k < text.len(); k++)
      expected_chars.push_back('{ascii: CHAR_W'(text[k]), last: (k == text.len() - 1)});
  endtask

  // Random value: a few zeros, some fully random words (every bit toggles),
  // the rest spread evenly over digit counts one to ten.
  function automatic logic [VALUE_W-1:0] random_value();
    int unsigned        sel;
    int unsigned        n_dig;
    int unsigned        k;
    logic [VALUE_W-1:0] lo;
    logic [VALUE_W-1:0] hi;
    sel = $urandom_range(99, 0);
    if (sel < 6) return '0;
    if (sel < 30) return $urandom;
    n_dig = $urandom_range(10, 1);
    lo    = 1;
    for (k = 1; k < n_dig; k++) lo = lo * 10;
    hi = (n_dig == 10) ? 32'hFFFF_FFFF : lo * 10 - 1;
    return $urandom_range(hi, lo);
  endfunction

  // Offer one value. Bursts of back-to-back transactions are broken by gaps
  // of random length, sometimes none; valid stays high across a burst, so it is never
  // lowered and raised in the same time step.
  task automatic offer_value(input logic [VALUE_W-1:0] value, input string text);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      case ($urandom_range(9, 0))
        0, 1, 2: gap = 0;
        3:       gap = $urandom_range(80, 30);
        default: gap = $urandom_range(20, 1);
      endcase
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_value <= value;
    // wait for the input transaction; in_ready is read before the edge updates
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (text.len() != 0) queue_text(text);
    else predict_chars(value);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: out_ready follows a mode that changes between segments of random
  // length (always ready, coin flip, mostly stalled, fixed duty pattern). Once the
  // random phase starts it holds off for a long stretch so the block backs
  // up and drops in_ready while the sender keeps offering.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned mode;
    int unsigned seg;
    int unsigned k;
    forever begin
      mode = $urandom_range(3, 0);
      seg  = $urandom_range(200, 20);
      for (k = 0; k < seg; k++) begin
        @(negedge clk);
        if (holdoff_req && !holdoff_done) begin
          out_ready <= 1'b0;
          repeat (400) @(negedge clk);
          holdoff_done = 1'b1;
        end
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(1, 0));
          2:       out_ready <= ($urandom_range(3, 0) == 0);
          default: out_ready <= ((k % 7) < 4);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every accepted character is compared field by field against the
  // oldest expectation; each mismatch is printed and counted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        err_count++;
        $display("%0t: unexpected char: expected none, actual %0d last %0b",
                 $time, out_ascii_char, out_last_char);
      end else begin
        got_char = expected_chars.pop_front();
        if (out_ascii_char !== got_char.ascii) begin
          err_count++;
          $display("%0t: ascii_char mismatch: expected %0d, actual %0d",
                   $time, got_char.ascii, out_ascii_char);
        end
        if (out_last_char !== got_char.last) begin
          err_count++;
          $display("%0t: last_char mismatch: expected %0b, actual %0b",
                   $time, got_char.last, out_last_char);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed rows, random values, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int i;

    // zero and the largest word are read straight off the spec; one digit is
    // the shortest nonzero run. Ten digits exercise the full-size digit
    // buffer; the alternating patterns toggle every input bit.
    dir_value[0]  = 32'd0;          dir_text[0]  = "0";
    dir_value[1]  = 32'hFFFF_FFFF;  dir_text[1]  = "4294967295 ";
    dir_value[2]  = 32'd1;          dir_text[2]  = "1 ";
    dir_value[3]  = 32'd9;          dir_text[3]  = "";
    dir_value[4]  = 32'd10;         dir_text[4]  = "";
    dir_value[5]  = 32'd99;         dir_text[5]  = "";
    dir_value[6]  = 32'd100;        dir_text[6]  = "";
    dir_value[7]  = 32'd12345;      dir_text[7]  = "";
    dir_value[8]  = 32'd123456;     dir_text[8]  = "";
    dir_value[9]  = 32'd999999;     dir_text[9]  = "";
    dir_value[10] = 32'd1000000;    dir_text[10] = "";
    dir_value[11] = 32'd0;          dir_text[11] = "0";
    dir_value[12] = 32'd1000000000; dir_text[12] = "";
    dir_value[13] = 32'hFFFF_FFFE;  dir_text[13] = "";
    dir_value[14] = 32'h8000_0000;  dir_text[14] = "";
    dir_value[15] = 32'hAAAA_AAAA;  dir_text[15] = "";
    dir_value[16] = 32'h5555_5555;  dir_text[16] = "";
    dir_value[17] = 32'd4000000000; dir_text[17] = "";
    dir_value[18] = 32'd65535;      dir_text[18] = "";
    dir_value[19] = 32'd5;          dir_text[19] = "";

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < N_DIR; i++)
      offer_value(dir_value[i], dir_text[i]);

    // random phase opens with the receiver's long hold-off
    holdoff_req = 1'b1;
    for (i = 0; i < N_RAND; i++)
      offer_value(random_value(), "");

    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then give the block time to show any stray characters
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (err_count == 0) begin
      $display("PASS binary_to_decimal_ascii");
    end else begin
      $display("FAIL binary_to_decimal_ascii");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
hdl/b2da_pkg.sv
hdl/b2da_div10.sv
hdl/binary_to_decimal_ascii.sv
test/binary_to_decimal_ascii_tb.sv
